[rtl/chmap_pkg.sv]
// Package for the chained hash map engine.
// Holds the beat payload types and the state machine encoding. No dependencies.
package chmap_pkg;

    typedef struct packed {
        logic        mode;
        logic [63:0] key;
        logic [31:0] position;
    } chmap_in_t;

    typedef struct packed {
        logic        found;
        logic [31:0] position_out;
        logic        status;
    } chmap_out_t;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    localparam int KEY_BITS       = 64;
    localparam int BITS_PER_CYCLE = 8;

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_HASH  = 8'b0000_0100,
        ST_SRD   = 8'b0000_1000,
        ST_SCHK  = 8'b0001_0000,
        ST_NRD   = 8'b0010_0000,
        ST_NCHK  = 8'b0100_0000,
        ST_RESP  = 8'b1000_0000
    } chmap_state_t;

endpackage

[rtl/chmap_mod.sv]
// Bucket index unit: key modulo the table size, eight key bits per cycle.
// Depends on chmap_pkg.
module chmap_mod import chmap_pkg::*; #(
    parameter int TABLE_SIZE = 1021
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [KEY_BITS-1:0]           key,
    output logic                          done,
    output logic [$clog2(TABLE_SIZE)-1:0] bucket
);

    localparam int RW     = $clog2(TABLE_SIZE);
    localparam int CYCLES = KEY_BITS / BITS_PER_CYCLE;
    localparam int CW     = $clog2(CYCLES);

    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [RW-1:0]       rem_reg, rem_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;

    always_comb begin
        logic [RW:0] t;
        logic [RW-1:0] r;
        r = rem_reg;
        for (int i = 0; i < BITS_PER_CYCLE; i++) begin
            t = {r, key_reg[KEY_BITS-1-i]};
            if (t >= (RW+1)'(TABLE_SIZE)) begin
                t = t - (RW+1)'(TABLE_SIZE);
            end
            r = t[RW-1:0];
        end
        key_next  = key_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            key_next  = key;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            key_next = key_reg << BITS_PER_CYCLE;
            rem_next = r;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(CYCLES - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done   = done_reg;
    assign bucket = rem_reg;

endmodule

[rtl/chained_hash_map_engine_core.sv]
// Steps: the bucket index is computed, the head slot is read and checked, then each chain node is read and checked,
// and the response is sent. One beat at a time: s_ready is high only while idle.
// Reset clears control state, then a pass over all TABLE_SIZE slots empties the slot memory.
module chained_hash_map_engine_core import chmap_pkg::*; #(
    parameter int TABLE_SIZE    = 1021,
    parameter int POOL_SIZE     = 1024,
    parameter int POSITION_BITS = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  chmap_in_t  s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output chmap_out_t m_data
);

    localparam int RW  = $clog2(TABLE_SIZE);
    localparam int LW  = $clog2(POOL_SIZE + 1);
    localparam int NAW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int PB  = POSITION_BITS;
    localparam int SW  = 1 + KEY_BITS + PB + LW;
    localparam int NW  = KEY_BITS + PB + LW;
    localparam logic [LW-1:0] LINK_NULL = LW'(POOL_SIZE);

    logic [SW-1:0] slot_mem [TABLE_SIZE];
    logic [NW-1:0] node_mem [POOL_SIZE];
    logic [SW-1:0] slot_q;
    logic [NW-1:0] node_q;

    chmap_state_t state_reg, state_next;
    logic                mode_reg, mode_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [PB-1:0]       pos_reg, pos_next;
    logic [RW-1:0]       clr_reg, clr_next;
    logic [LW-1:0]       used_reg, used_next;
    logic [LW-1:0]       cur_reg, cur_next;
    logic [LW-1:0]       new_reg, new_next;
    logic [LW-1:0]       steps_reg, steps_next;
    logic                fin_reg, fin_next;
    chmap_out_t          res_reg, res_next;
    logic                m_valid_reg, m_valid_next;
    chmap_out_t          m_data_reg, m_data_next;

    logic          hash_start, hash_done;
    logic [RW-1:0] bucket;

    logic          slot_we;
    logic [RW-1:0] slot_waddr;
    logic [SW-1:0] slot_wdata;
    logic          node_we;
    logic [NAW-1:0] node_waddr;
    logic [NW-1:0] node_wdata;

    logic                s_valid_q_bit;
    logic [KEY_BITS-1:0] s_key_q, n_key_q;
    logic [PB-1:0]       s_pos_q, n_pos_q;
    logic [LW-1:0]       s_link_q, n_link_q;
    logic [63:0]         pos_wide;

    assign s_valid_q_bit = slot_q[SW-1];
    assign s_key_q  = slot_q[LW+PB +: KEY_BITS];
    assign s_pos_q  = slot_q[LW +: PB];
    assign s_link_q = slot_q[LW-1:0];
    assign n_key_q  = node_q[LW+PB +: KEY_BITS];
    assign n_pos_q  = node_q[LW +: PB];
    assign n_link_q = node_q[LW-1:0];
    assign pos_wide = {32'b0, s_data.position};

    chmap_mod #(.TABLE_SIZE(TABLE_SIZE)) u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hash_start),
        .key     (s_data.key),
        .done    (hash_done),
        .bucket  (bucket)
    );

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        logic [63:0] hit_wide;
        hit_wide     = '0;
        state_next   = state_reg;
        mode_next    = mode_reg;
        key_next     = key_reg;
        pos_next     = pos_reg;
        clr_next     = clr_reg;
        used_next    = used_reg;
        cur_next     = cur_reg;
        new_next     = new_reg;
        steps_next   = steps_reg;
        fin_next     = fin_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        hash_start   = 1'b0;
        slot_we      = 1'b0;
        slot_waddr   = bucket;
        slot_wdata   = {1'b1, key_reg, pos_reg, s_link_q};
        node_we      = 1'b0;
        node_waddr   = used_reg[NAW-1:0];
        node_wdata   = {key_reg, pos_reg, LINK_NULL};
        case (state_reg)
            ST_CLEAR: begin
                slot_we    = 1'b1;
                slot_waddr = clr_reg;
                slot_wdata = {1'b0, {(KEY_BITS+PB){1'b0}}, LINK_NULL};
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == RW'(TABLE_SIZE - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    mode_next  = s_data.mode;
                    key_next   = s_data.key;
                    pos_next   = pos_wide[PB-1:0];
                    hash_start = 1'b1;
                    state_next = ST_HASH;
                end
            end
            ST_HASH: begin
                if (hash_done) begin
                    state_next = ST_SRD;
                end
            end
            ST_SRD: begin
                state_next = ST_SCHK;
            end
            ST_SCHK: begin
                res_next   = '{found: 1'b0, position_out: 32'b0, status: STATUS_OK};
                steps_next = '0;
                fin_next   = 1'b0;
                cur_next   = s_link_q;
                state_next = ST_RESP;
                if (mode_reg == MODE_LOOKUP) begin
                    if (s_valid_q_bit && s_key_q == key_reg) begin
                        hit_wide = 64'(s_pos_q);
                        res_next.found        = 1'b1;
                        res_next.position_out = hit_wide[31:0];
                    end else if (s_link_q < LINK_NULL) begin
                        state_next = ST_NRD;
                    end
                end else if (!s_valid_q_bit) begin
                    slot_we = 1'b1;
                end else if (used_reg >= LINK_NULL) begin
                    res_next.status = STATUS_FULL;
                end else begin
                    node_we   = 1'b1;
                    new_next  = used_reg;
                    used_next = used_reg + 1'b1;
                    if (s_link_q < LINK_NULL) begin
                        state_next = ST_NRD;
                    end else begin
                        slot_we    = 1'b1;
                        slot_wdata = {1'b1, s_key_q, s_pos_q, used_reg};
                    end
                end
            end
            ST_NRD: begin
                state_next = ST_NCHK;
            end
            ST_NCHK: begin
                state_next = ST_RESP;
                if (mode_reg == MODE_LOOKUP) begin
                    if (n_key_q == key_reg) begin
                        hit_wide = 64'(n_pos_q);
                        res_next.found        = 1'b1;
                        res_next.position_out = hit_wide[31:0];
                    end else if (steps_reg + 1'b1 != LINK_NULL && n_link_q < LINK_NULL) begin
                        steps_next = steps_reg + 1'b1;
                        cur_next   = n_link_q;
                        state_next = ST_NRD;
                    end
                end else if (fin_reg || !(n_link_q < LINK_NULL)) begin
                    node_we    = 1'b1;
                    node_waddr = cur_reg[NAW-1:0];
                    node_wdata = {n_key_q, n_pos_q, new_reg};
                end else begin
                    steps_next = steps_reg + 1'b1;
                    cur_next   = n_link_q;
                    fin_next   = (steps_reg + 1'b1 == LINK_NULL);
                    state_next = ST_NRD;
                end
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        slot_q <= slot_mem[bucket];
    end

    always_ff @(posedge aclk) begin
        if (node_we) begin
            node_mem[node_waddr] <= node_wdata;
        end
        node_q <= node_mem[cur_reg[NAW-1:0]];
    end

    always_ff @(posedge aclk) begin
        mode_reg   <= mode_next;
        key_reg    <= key_next;
        pos_reg    <= pos_next;
        cur_reg    <= cur_next;
        new_reg    <= new_next;
        steps_reg  <= steps_next;
        fin_reg    <= fin_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= LINK_NULL)
        else $error("Node count exceeds the pool size.");

    a_used_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (used_reg != $past(used_reg)) |-> (used_reg == $past(used_reg) + 1'b1))
        else $error("Node count moved by more than one.");

    a_full_not_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == STATUS_FULL) |-> !m_data.found)
        else $error("Dropped insert reported as a hit.");

    a_node_write_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (node_we && state_reg == ST_SCHK) |-> (used_reg < LINK_NULL))
        else $error("Node allocated from a full pool.");

endmodule

[verif/chained_hash_map_engine_core_tb.sv]
// Self-checking testbench for the chained hash map engine core.
// Depends on chmap_pkg and chained_hash_map_engine_core; keeps its own copy of the table.
module chained_hash_map_engine_core_tb;
    import chmap_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TBL = 1021;
    localparam int POOL = 1024;
    localparam int NULL_LINK = POOL;

    class hash_map_scoreboard;
        bit          head_used[TBL];
        logic [63:0] head_key[TBL];
        logic [31:0] head_pos[TBL];
        int          head_next[TBL];
        logic [63:0] chain_key[POOL];
        logic [31:0] chain_pos[POOL];
        int          chain_next[POOL];
        int          chain_count;
        chmap_out_t  pending[$];
        int          errors;

        function void clear_table();
            for (int i = 0; i < TBL; i++) begin
                head_used[i] = 0;
                head_next[i] = NULL_LINK;
            end
            chain_count = 0;
            errors = 0;
        endfunction

        function bit key_present(logic [63:0] k);
            int b;
            int cur;
            b = int'(k % TBL);
            if (head_used[b] && head_key[b] == k) return 1;
            cur = head_next[b];
            while (cur < POOL) begin
                if (chain_key[cur] == k) return 1;
                cur = chain_next[cur];
            end
            return 0;
        endfunction

        function void note_input(chmap_in_t d);
            chmap_out_t r;
            int b;
            int cur;
            int n;
            r = '0;
            b = int'(d.key % TBL);
            if (d.mode == MODE_INSERT) begin
                if (!head_used[b]) begin
                    head_used[b] = 1;
                    head_key[b] = d.key;
                    head_pos[b] = d.position;
                end else if (chain_count >= POOL) begin
                    r.status = STATUS_FULL;
                end else begin
                    n = chain_count++;
                    chain_key[n] = d.key;
                    chain_pos[n] = d.position;
                    chain_next[n] = NULL_LINK;
                    if (head_next[b] >= POOL) begin
                        head_next[b] = n;
                    end else begin
                        cur = head_next[b];
                        while (chain_next[cur] < POOL) cur = chain_next[cur];
                        chain_next[cur] = n;
                    end
                end
            end else begin
                if (head_used[b] && head_key[b] == d.key) begin
                    r.found = 1;
                    r.position_out = head_pos[b];
                end else begin
                    cur = head_next[b];
                    while (cur < POOL) begin
                        if (chain_key[cur] == d.key) begin
                            r.found = 1;
                            r.position_out = chain_pos[cur];
                            break;
                        end
                        cur = chain_next[cur];
                    end
                end
            end
            pending.push_back(r);
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check_result(chmap_out_t got);
            chmap_out_t exp;
            if (pending.size() == 0) begin
                report($sformatf("unexpected beat %p", got));
                return;
            end
            exp = pending.pop_front();
            if (got.found !== exp.found)
                report($sformatf("found %0b, expected %0b", got.found, exp.found));
            if (got.position_out !== exp.position_out)
                report($sformatf("position_out %h, expected %h", got.position_out,
                    exp.position_out));
            if (got.status !== exp.status)
                report($sformatf("status %0b, expected %0b", got.status, exp.status));
        endtask
    endclass

    logic       aclk = 0;
    logic       aresetn = 0;
    logic       s_valid = 0;
    logic       s_ready;
    chmap_in_t  s_data = '0;
    logic       m_valid;
    logic       m_ready = 0;
    chmap_out_t m_data;

    hash_map_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off_cycles = 0;
    logic [63:0] used_keys[$];

    chained_hash_map_engine_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
        if (aresetn && s_valid && s_ready) sb.note_input(s_data);
    end

    always @(posedge aclk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_ready <= 0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task send_beat(logic mode, logic [63:0] k, logic [31:0] p);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_data <= '{mode: mode, key: k, position: p};
        do @(posedge aclk); while (!s_ready);
        if (mode == MODE_INSERT) used_keys.push_back(k);
    endtask

    task wait_drained();
        s_valid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
    endtask

    function logic [63:0] rand_key();
        logic [63:0] k;
        case ($urandom_range(3))
            0: k = {$urandom, $urandom};
            1: k = 64'($urandom_range(40)) * TBL + 64'($urandom_range(7));
            default: k = used_keys.size() ? used_keys[$urandom_range(used_keys.size() - 1)]
                                          : {$urandom, $urandom};
        endcase
        return k;
    endfunction

    task random_phase(int count, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (count) begin
            send_beat(($urandom_range(99) < 55) ? MODE_INSERT : MODE_LOOKUP,
                rand_key(), $urandom);
        end
    endtask

    initial begin
        sb.clear_table();
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        send_beat(MODE_LOOKUP, 64'd0, 32'd0);
        send_beat(MODE_INSERT, 64'd0, 32'hFFFF_FFFF);
        send_beat(MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
        send_beat(MODE_INSERT, 64'd0, 32'h1234_5678);
        send_beat(MODE_INSERT, 64'(TBL), 32'hA5A5_5A5A);
        send_beat(MODE_INSERT, 64'(2 * TBL), 32'h5A5A_A5A5);
        send_beat(MODE_LOOKUP, 64'd0, 32'hDEAD_BEEF);
        send_beat(MODE_LOOKUP, 64'(2 * TBL), 32'd0);
        send_beat(MODE_LOOKUP, 64'(3 * TBL), 32'd0);
        send_beat(MODE_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
        send_beat(MODE_LOOKUP, 64'd1, 32'd0);
        random_phase(120, 0, 0);
        random_phase(120, 72, 0);
        random_phase(120, 0, 72);
        random_phase(120, 22, 22);
        wait_drained();
        hold_off_cycles <= 400;
        random_phase(30, 0, 0);
        wait_drained();
        // Fill the rest of the node pool through one bucket so later colliding inserts must be dropped.
        send_idle_pct = 0;
        recv_stall_pct = 10;
        while (sb.chain_count < POOL) send_beat(MODE_INSERT, 64'(5 + sb.chain_count * TBL),
            $urandom);
        repeat (12) send_beat(MODE_INSERT, {$urandom, $urandom}, $urandom);
        send_beat(MODE_INSERT, 64'd5, 32'd1);
        send_beat(MODE_LOOKUP, 64'(5 + 100 * TBL), 32'd0);
        random_phase(100, 22, 22);
        wait_drained();
        repeat (100) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("[chained_hash_map_engine_core] OK");
        end else begin
            $display("[chained_hash_map_engine_core] ERROR");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("[chained_hash_map_engine_core] ERROR");
        $finish;
    end
endmodule

[files.f]
rtl/chmap_pkg.sv
rtl/chmap_mod.sv
rtl/chained_hash_map_engine_core.sv
verif/chained_hash_map_engine_core_tb.sv
